[hdl/owrs_pkg.sv]
// ----------------------------------------------------------------------------
// owrs_pkg
// Types, codes and constants shared by the 1-Wire ROM search engine.
// ----------------------------------------------------------------------------
`default_nettype none

package owrs_pkg;

   localparam int unsigned ID_BITS     = 64;
   localparam int unsigned MAX_DEVICES = 8;
   localparam int unsigned POS_W       = 7;
   localparam int unsigned COUNT_W     = 8;
   localparam logic [7:0]  CRC_POLY    = 8'h8C;

   localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};
   localparam logic [COUNT_W-1:0] MAX_DEV_CNT = COUNT_W'(MAX_DEVICES);
   localparam logic [POS_W-1:0]   POS_FIRST   = POS_W'(1);
   localparam logic [POS_W-1:0]   POS_LAST    = POS_W'(ID_BITS);

   // Event codes.
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_PASS  = 2'd1;
   localparam logic [1:0] OP_BITS  = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   // Status codes.
   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_CONTINUE  = 3'd1;
   localparam logic [2:0] ST_PASS_MORE = 3'd2;
   localparam logic [2:0] ST_DONE_OK   = 3'd3;
   localparam logic [2:0] ST_DONE_ERR  = 3'd4;

   typedef struct packed {
      logic [1:0] operation;
      logic       presence;
      logic       id_bit;
      logic       complement_bit;
   } req_word_type;

   typedef struct packed {
      logic [2:0]         status;
      logic               write_valid;
      logic               direction;
      logic               device_found;
      logic [2:0]         device_index;
      logic [ID_BITS-1:0] rom_id;
      logic [3:0]         devices_total;
   } rsp_word_type;

endpackage

`default_nettype wire

[hdl/one_wire_rom_search_top.sv]
// Latency: a result word is valid in the cycle after its request word is taken.
// Throughput: one request word per cycle; the single result register stalls
// the request side only while it holds a word that the receiver has not taken.
// Reset (synchronous, active high) clears the search state and the result
// valid flag; the bit position returns to the first ID bit.
// ----------------------------------------------------------------------------
// one_wire_rom_search_top
// Binary-tree SEARCH ROM engine: decides each ID bit, tracks the last
// zero-branch discrepancy, runs a serial CRC-8 and reports found devices.
// ----------------------------------------------------------------------------
`default_nettype none

module one_wire_rom_search_top
   import owrs_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_word_type req_word,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_word_type      rsp_word
);

   logic [ID_BITS-1:0] rom_id_ff,      rom_id_in;
   logic [POS_W-1:0]   last_branch_ff, last_branch_in;
   logic [POS_W-1:0]   pass_branch_ff, pass_branch_in;
   logic [POS_W-1:0]   bit_pos_ff,     bit_pos_in;
   logic [7:0]         crc_ff,         crc_in;
   logic [COUNT_W-1:0] found_cnt_ff,   found_cnt_in;
   logic               search_ff,      search_in;
   logic               pass_ff,        pass_in;
   logic               rsp_valid_ff;
   rsp_word_type       rsp_word_ff,    rsp_word_in;
   logic               req_take;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_take  = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_comb begin
      logic [POS_W-1:0]   pos;
      logic [5:0]         shift;
      logic               dir;
      logic               mix;
      logic [7:0]         crc_step;
      logic [2:0]         end_status;

      rom_id_in      = rom_id_ff;
      last_branch_in = last_branch_ff;
      pass_branch_in = pass_branch_ff;
      bit_pos_in     = bit_pos_ff;
      crc_in         = crc_ff;
      found_cnt_in   = found_cnt_ff;
      search_in      = search_ff;
      pass_in        = pass_ff;

      pos = bit_pos_ff;
      if (pos < POS_FIRST || pos > POS_LAST) begin
         pos = POS_FIRST;
      end
      shift = 6'(pos - POS_FIRST);

      // Forced bit when the two reads disagree, else follow the branch plan.
      if (req_word.id_bit != req_word.complement_bit) begin
         dir = req_word.id_bit;
      end else if (pos < last_branch_ff) begin
         dir = rom_id_ff[shift];
      end else begin
         dir = (pos == last_branch_ff);
      end

      mix      = crc_ff[0] ^ dir;
      crc_step = (crc_ff >> 1) ^ (mix ? CRC_POLY : 8'h00);

      end_status = (found_cnt_ff != '0) ? ST_DONE_OK : ST_DONE_ERR;

      rsp_word_in = '0;

      unique case (req_word.operation)
         OP_START: begin
            rom_id_in      = '0;
            last_branch_in = '0;
            pass_branch_in = '0;
            bit_pos_in     = POS_FIRST;
            crc_in         = '0;
            found_cnt_in   = '0;
            search_in      = 1'b1;
            pass_in        = 1'b0;
            rsp_word_in.status = ST_CONTINUE;
         end
         OP_PASS: begin
            if (!search_ff) begin
               rsp_word_in.status = ST_IDLE;
            end else if (!req_word.presence) begin
               search_in = 1'b0;
               pass_in   = 1'b0;
               rsp_word_in.status = end_status;
            end else begin
               pass_in        = 1'b1;
               bit_pos_in     = POS_FIRST;
               pass_branch_in = '0;
               crc_in         = '0;
               rsp_word_in.status = ST_CONTINUE;
            end
         end
         OP_BITS: begin
            if (!pass_ff) begin
               rsp_word_in.status = ST_IDLE;
            end else if (req_word.id_bit && req_word.complement_bit) begin
               // Nobody pulled the bus low in either slot.
               search_in = 1'b0;
               pass_in   = 1'b0;
               rsp_word_in.status = end_status;
            end else begin
               if (req_word.id_bit == req_word.complement_bit && !dir) begin
                  pass_branch_in = pos;
               end
               rom_id_in[shift] = dir;
               crc_in           = crc_step;
               rsp_word_in.write_valid = 1'b1;
               rsp_word_in.direction   = dir;
               if (pos < POS_LAST) begin
                  bit_pos_in = pos + POS_FIRST;
                  rsp_word_in.status = ST_CONTINUE;
               end else begin
                  pass_in    = 1'b0;
                  bit_pos_in = POS_FIRST;
                  if (crc_step != 8'h00) begin
                     search_in = 1'b0;
                     rsp_word_in.status = end_status;
                  end else begin
                     if (found_cnt_ff != COUNT_MAX) begin
                        found_cnt_in = found_cnt_ff + COUNT_W'(1);
                     end
                     last_branch_in = pass_branch_in;
                     if (pass_branch_in == '0 || found_cnt_in >= MAX_DEV_CNT) begin
                        search_in = 1'b0;
                        rsp_word_in.status = ST_DONE_OK;
                     end else begin
                        rsp_word_in.status = ST_PASS_MORE;
                     end
                     rsp_word_in.device_found = 1'b1;
                     rsp_word_in.device_index = found_cnt_ff[2:0];
                     rsp_word_in.rom_id       = rom_id_in;
                  end
               end
            end
         end
         OP_NONE: begin
            rsp_word_in.status = ST_IDLE;
         end
         default: begin
            rsp_word_in.status = ST_IDLE;
         end
      endcase

      rsp_word_in.devices_total = found_cnt_in[3:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_id_ff      <= '0;
         last_branch_ff <= '0;
         pass_branch_ff <= '0;
         bit_pos_ff     <= POS_FIRST;
         crc_ff         <= '0;
         found_cnt_ff   <= '0;
         search_ff      <= 1'b0;
         pass_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (req_take) begin
            rom_id_ff      <= rom_id_in;
            last_branch_ff <= last_branch_in;
            pass_branch_ff <= pass_branch_in;
            bit_pos_ff     <= bit_pos_in;
            crc_ff         <= crc_in;
            found_cnt_ff   <= found_cnt_in;
            search_ff      <= search_in;
            pass_ff        <= pass_in;
            rsp_valid_ff   <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff   <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   // A pass can only run inside an active search.
   a_pass_in_search: assert property (@(posedge clock) disable iff (reset)
      pass_ff |-> search_ff)
      else $error("pass active without an active search");

   // A found device is always reported on the 64th written bit.
   a_found_writes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.device_found) |->
         (rsp_word.write_valid &&
          (rsp_word.status == ST_PASS_MORE || rsp_word.status == ST_DONE_OK)))
      else $error("device found without a final bit write");

   // Taking a start word always leaves a search running with no pass.
   a_start_opens: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_word.operation == OP_START) |=> (search_ff && !pass_ff))
      else $error("start word did not open a search");

   // A device found ends the pass and rewinds the bit position.
   a_found_rewinds: assert property (@(posedge clock) disable iff (reset)
      (req_take && rsp_word_in.device_found) |=>
         (!pass_ff && bit_pos_ff == POS_FIRST))
      else $error("pass still running after a device was found");

   // The bit position never leaves the ID range.
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      (bit_pos_ff >= POS_FIRST) && (bit_pos_ff <= POS_LAST))
      else $error("bit position out of range");

endmodule

`default_nettype wire
